// ----- hw/rtl/ose_pkg.sv -----
// ----------------------------------------------------------------------------
// ose_pkg
// Shared constants and types for the ocean spectrum time evolution core.
// ----------------------------------------------------------------------------
package ose_pkg;

    localparam int MAX_GRID   = 64;
    localparam int TRIG_BITS  = 16;

    localparam int IDX_W      = $clog2(MAX_GRID);
    localparam int NW         = $clog2(MAX_GRID + 1);
    localparam int DEPTH      = MAX_GRID * MAX_GRID;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int AMP_W      = 24;
    localparam int FREQ_W     = 24;
    localparam int TIME_W     = 32;
    localparam int SPEC_W     = 25;
    localparam int GS_W       = 7;
    localparam int WORD_W     = 2 * AMP_W + FREQ_W;
    localparam int PHASE_W    = FREQ_W + TIME_W;
    localparam int TRIG_LAT   = 8;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic REG_GRID_SIZE = 1'b0;
    localparam logic [GS_W-1:0] GRID_RESET = GS_W'(64);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // floor(2^64 / 2pi), split in halves
    localparam logic [31:0] INV_2PI_HI = 32'h28BE_60DB;
    localparam logic [31:0] INV_2PI_LO = 32'h9391_054A;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    typedef logic [31:0] coef_arr_t [0:5];
    // odd polynomial of sin(pi/2*x), highest order first
    localparam coef_arr_t SIN_COEF = '{
        32'd3864, 32'd172272, 32'd5026995,
        32'd85569306, 32'd693598668, 32'd1686629713
    };

    typedef struct packed {
        logic                     err;
        logic                     eval;
        logic signed [SPEC_W-1:0] sum_r;
        logic signed [SPEC_W-1:0] sum_i;
        logic signed [SPEC_W-1:0] dif_r;
        logic signed [SPEC_W-1:0] dif_i;
    } side_t;

endpackage

// ----- hw/rtl/ose_if.sv -----
// ----------------------------------------------------------------------------
// ose_in_if / ose_out_if
// Valid/ready channels carrying spectrum requests and results.
// ----------------------------------------------------------------------------
interface ose_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [5:0]         x_index;
    logic [5:0]         z_index;
    logic signed [23:0] amp_real;
    logic signed [23:0] amp_imag;
    logic [23:0]        ang_freq;
    logic [31:0]        time_value;

    modport source (
        output valid, func, x_index, z_index, amp_real, amp_imag, ang_freq, time_value,
        input  ready
    );
    modport sink (
        input  valid, func, x_index, z_index, amp_real, amp_imag, ang_freq, time_value,
        output ready
    );
endinterface

interface ose_out_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] spec_real;
    logic signed [24:0] spec_imag;
    logic               range_error;

    modport source (
        output valid, spec_real, spec_imag, range_error,
        input  ready
    );
    modport sink (
        input  valid, spec_real, spec_imag, range_error,
        output ready
    );
endinterface

// ----- hw/rtl/ocean_spectrum_time_evolution_core.sv -----
// ----------------------------------------------------------------------------
// ocean_spectrum_time_evolution_core
// Table of h0 and omega per grid cell; evaluates h0(k)e^{iwt}+conj(h0(-k))e^{-iwt}.
// ----------------------------------------------------------------------------
//  channel    dir  handshake       content
//  spec_in    in   valid/ready     func, x/z index, amplitude, frequency, time
//  spec_out   out  valid/ready     spec_real, spec_imag, range_error
//  apb        in   psel/penable    grid_size at byte address 0
//
//  one request per cycle unless the output stalls; each result passes through the
//  phase multiply split into partial products and the eight-stage sine/cosine
//  polynomial pipelines
//  a stalled output freezes the whole pipeline; nothing is dropped or repeated
//  rst_n clears valid bits and grid_size (64); table contents are not cleared
// ----------------------------------------------------------------------------
module ocean_spectrum_time_evolution_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ose_pkg::PADDR_W-1:0]  paddr,
    input  logic [ose_pkg::PDATA_W-1:0]  pwdata,
    output logic [ose_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    ose_in_if.sink                       spec_in,
    ose_out_if.source                    spec_out
);
    import ose_pkg::*;

    logic [GS_W-1:0]   grid_size_reg;
    logic [NW-1:0]     n_eff;
    logic              en;
    logic              accept;
    logic              in_err;
    logic [IDX_W-1:0]  xi, zi, mx, mz;
    logic [ADDR_W-1:0] addr_k, addr_mk;
    logic              we;
    logic [WORD_W-1:0] rd_a, rd_b;

    // pipeline valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vm_reg, vf_reg;
    logic vd_reg [0:TRIG_LAT-1];

    // payload
    logic                     err1_reg, eval1_reg;
    logic [TIME_W-1:0]        time1_reg;
    logic [PHASE_W-1:0]       p2_reg;
    side_t                    side2_reg, side3_reg, side4_reg, side5_reg, side_next;
    side_t                    sd_reg [0:TRIG_LAT-1];
    logic [63:0]              t0_reg, ta_reg;
    logic [55:0]              tb_reg, td_reg;
    logic [33:0]              mid_reg;
    logic [31:0]              hs_reg;
    logic [31:0]              frac;
    logic [TRIG_BITS-1:0]     ang5_reg, cang5_reg;
    logic signed [31:0]       sin_w, cos_w;
    logic signed [56:0]       pa_reg, pb_reg, pc_reg, pd_reg;
    logic                     errm_reg, evalm_reg;
    logic signed [SPEC_W-1:0] re_next, im_next;

    function automatic logic signed [SPEC_W-1:0] round_sat(input logic signed [57:0] v);
        logic signed [57:0] r;
        r = (v + 58'sd536870912) >>> 30;
        if (r > 58'sd16777215)
        begin
            return 25'sh0FF_FFFF;
        end
        else if (r < -58'sd16777216)
        begin
            return 25'sh100_0000;
        end
        return r[SPEC_W-1:0];
    endfunction

    // configuration
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_GRID_SIZE)
        begin
            prdata = PDATA_W'(grid_size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_GRID_SIZE)
        begin
            grid_size_reg <= pwdata[GS_W-1:0];
        end
    end

    // request decode
    assign en             = !vf_reg || spec_out.ready;
    assign spec_in.ready  = en;
    assign accept         = spec_in.valid && en;

    always_comb
    begin
        if (int'(grid_size_reg) < 2)
        begin
            n_eff = NW'(2);
        end
        else if (int'(grid_size_reg) > MAX_GRID)
        begin
            n_eff = NW'(MAX_GRID);
        end
        else
        begin
            n_eff = NW'(grid_size_reg);
        end
        in_err  = (int'(spec_in.x_index) >= int'(n_eff))
               || (int'(spec_in.z_index) >= int'(n_eff));
        xi      = IDX_W'(spec_in.x_index);
        zi      = IDX_W'(spec_in.z_index);
        mx      = (xi == '0) ? '0 : IDX_W'(int'(n_eff) - int'(xi));
        mz      = (zi == '0) ? '0 : IDX_W'(int'(n_eff) - int'(zi));
        addr_k  = {zi, xi};
        addr_mk = {mz, mx};
    end

    assign we = accept && spec_in.func == FUNC_LOAD && !in_err;

    ose_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (we),
        .waddr   (addr_k),
        .wdata   ({spec_in.amp_real, spec_in.amp_imag, spec_in.ang_freq}),
        .re      (en),
        .raddr_a (addr_k),
        .raddr_b (addr_mk),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        side_next.err   = err1_reg;
        side_next.eval  = eval1_reg;
        side_next.sum_r = SPEC_W'($signed(rd_a[71:48])) + SPEC_W'($signed(rd_b[71:48]));
        side_next.sum_i = SPEC_W'($signed(rd_a[47:24])) + SPEC_W'($signed(rd_b[47:24]));
        side_next.dif_r = SPEC_W'($signed(rd_a[71:48])) - SPEC_W'($signed(rd_b[71:48]));
        side_next.dif_i = SPEC_W'($signed(rd_a[47:24])) - SPEC_W'($signed(rd_b[47:24]));
        frac            = hs_reg + 32'(mid_reg[33:32]);
        re_next         = round_sat(58'(pa_reg) - 58'(pb_reg));
        im_next         = round_sat(58'(pc_reg) + 58'(pd_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vm_reg <= 1'b0;
            vf_reg <= 1'b0;
            for (int k = 0; k < TRIG_LAT; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= spec_in.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vd_reg[0] <= v5_reg;
            for (int k = 1; k < TRIG_LAT; k++)
            begin
                vd_reg[k] <= vd_reg[k-1];
            end
            vm_reg    <= vd_reg[TRIG_LAT-1];
            vf_reg    <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err1_reg  <= in_err;
            eval1_reg <= spec_in.func == FUNC_EVAL && !in_err;
            time1_reg <= spec_in.time_value;

            p2_reg    <= PHASE_W'(64'(rd_a[23:0]) * 64'(time1_reg));
            side2_reg <= side_next;

            // bits 64..95 of phase times 1/2pi, from four partial products
            t0_reg    <= 64'(p2_reg[31:0]) * 64'(INV_2PI_LO);
            ta_reg    <= 64'(p2_reg[31:0]) * 64'(INV_2PI_HI);
            tb_reg    <= 56'(p2_reg[55:32]) * 56'(INV_2PI_LO);
            td_reg    <= 56'(p2_reg[55:32]) * 56'(INV_2PI_HI);
            side3_reg <= side2_reg;

            mid_reg   <= 34'(t0_reg[63:32]) + 34'(ta_reg[31:0]) + 34'(tb_reg[31:0]);
            hs_reg    <= td_reg[31:0] + ta_reg[63:32] + 32'(tb_reg[55:32]);
            side4_reg <= side3_reg;

            ang5_reg  <= frac[31:32-TRIG_BITS];
            cang5_reg <= frac[31:32-TRIG_BITS] + TRIG_BITS'(1 << (TRIG_BITS - 2));
            side5_reg <= side4_reg;

            sd_reg[0] <= side5_reg;
            for (int k = 1; k < TRIG_LAT; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end

            pa_reg    <= 57'(sd_reg[TRIG_LAT-1].sum_r) * 57'(cos_w);
            pb_reg    <= 57'(sd_reg[TRIG_LAT-1].sum_i) * 57'(sin_w);
            pc_reg    <= 57'(sd_reg[TRIG_LAT-1].dif_r) * 57'(sin_w);
            pd_reg    <= 57'(sd_reg[TRIG_LAT-1].dif_i) * 57'(cos_w);
            errm_reg  <= sd_reg[TRIG_LAT-1].err;
            evalm_reg <= sd_reg[TRIG_LAT-1].eval;

            spec_out.range_error <= errm_reg;
            spec_out.spec_real   <= evalm_reg ? re_next : '0;
            spec_out.spec_imag   <= evalm_reg ? im_next : '0;
        end
    end

    ose_trig u_sine (
        .clk  (clk),
        .en   (en),
        .ang  (ang5_reg),
        .sine (sin_w)
    );

    ose_trig u_cosine (
        .clk  (clk),
        .en   (en),
        .ang  (cang5_reg),
        .sine (cos_w)
    );

    assign spec_out.valid = vf_reg;

    a_err_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        spec_out.valid && spec_out.range_error |->
            spec_out.spec_real == '0 && spec_out.spec_imag == '0)
        else $error("range error result carries a value");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted request missing from first stage");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v1_reg) && $stable(v5_reg) && $stable(vm_reg) && $stable(vf_reg))
        else $error("pipeline moved during stall");

    a_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> !in_err && spec_in.func == FUNC_LOAD)
        else $error("table written by a rejected request");

endmodule

// ----- hw/rtl/ose_ram.sv -----
// ----------------------------------------------------------------------------
// ose_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ose_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- hw/rtl/ose_trig.sv -----
// ----------------------------------------------------------------------------
// ose_trig
// Pipelined sine of a full-turn angle, polynomial evaluated one term a stage.
// ----------------------------------------------------------------------------
module ose_trig (
    input  logic                           clk,
    input  logic                           en,
    input  logic [ose_pkg::TRIG_BITS-1:0]  ang,
    output logic signed [31:0]             sine
);
    import ose_pkg::*;

    logic [30:0] x_raw;
    logic [30:0] x_first;
    logic [30:0] x_r   [0:6];
    logic        neg_r [0:6];
    logic [30:0] x2_r  [0:4];
    logic [31:0] s_r   [0:4];
    logic [63:0] sq;
    logic [63:0] hp    [0:4];
    logic [63:0] fp;
    logic [31:0] mag;

    always_comb
    begin
        x_raw   = 31'(ang[TRIG_BITS-3:0]) << (32 - TRIG_BITS);
        x_first = ang[TRIG_BITS-2] ? (Q30_ONE - x_raw) : x_raw;
        sq      = 64'(x_r[0]) * 64'(x_r[0]);
        for (int k = 0; k < 5; k++)
        begin
            hp[k] = 64'((k == 0) ? SIN_COEF[0] : s_r[(k == 0) ? 0 : k - 1]) * 64'(x2_r[k]);
        end
        fp  = 64'(s_r[4]) * 64'(x_r[6]);
        mag = fp[61:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_r[0]   <= x_first;
            neg_r[0] <= ang[TRIG_BITS-1];
            x2_r[0]  <= sq[60:30];
            x_r[1]   <= x_r[0];
            neg_r[1] <= neg_r[0];
            for (int k = 0; k < 5; k++)
            begin
                s_r[k]     <= SIN_COEF[k+1] - hp[k][61:30];
                x_r[k+2]   <= x_r[k+1];
                neg_r[k+2] <= neg_r[k+1];
            end
            for (int k = 1; k < 5; k++)
            begin
                x2_r[k] <= x2_r[k-1];
            end
            sine <= neg_r[6] ? -$signed(mag) : $signed(mag);
        end
    end

endmodule
